>>> rtl/lnerr_pkg.sv
// Shared types, constants and helper functions of the linear excess-relative-risk block.
`default_nettype none
package lnerr_pkg;

  typedef logic signed [31:0] q16_t;

  localparam int N_LIN    = 3;
  localparam int N_LOGLIN = 4;
  localparam int SET_MAX  = 65535;

  localparam logic [3:0] REG_LIN_A   = 4'd0;
  localparam logic [3:0] REG_LIN_B   = 4'd1;
  localparam logic [3:0] REG_LIN_C   = 4'd2;
  localparam logic [3:0] REG_LOG_A   = 4'd3;
  localparam logic [3:0] REG_LOG_B   = 4'd4;
  localparam logic [3:0] REG_LOG_C   = 4'd5;
  localparam logic [3:0] REG_LOG_D   = 4'd6;
  localparam logic [3:0] REG_DOSE_SEL = 4'd7;

  localparam logic signed [31:0] EXP_HI   = 32'sd681392;
  localparam logic signed [31:0] EXP_LO   = -32'sd817668;
  localparam logic [20:0]        EXP_OFFS = 21'd817668;
  localparam logic [15:0]        LN2_Q16  = 16'd45426;
  // floor(2^32 / ln2 in Q16.16), used for the range reduction quotient.
  localparam logic [32:0]        LN2_RECIP = 33'd94548;
  localparam logic [31:0]        ONE_Q30  = 32'h4000_0000;
  localparam logic [3:0]         HORNER_TERMS = 4'd10;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};

  localparam logic [1:0] OP_CONTRIB = 2'd0;
  localparam logic [1:0] OP_CASE    = 2'd1;
  localparam logic [1:0] OP_COUNT   = 2'd2;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_MAC   = 14'b00000000000010,
    ST_EXP0  = 14'b00000000000100,
    ST_EXP1  = 14'b00000000001000,
    ST_HMUL  = 14'b00000000010000,
    ST_HDIV  = 14'b00000000100000,
    ST_HCOR  = 14'b00000001000000,
    ST_EXPF  = 14'b00000010000000,
    ST_RMUL  = 14'b00000100000000,
    ST_RACC  = 14'b00001000000000,
    ST_DLOAD = 14'b00010000000000,
    ST_DITER = 14'b00100000000000,
    ST_DFIN  = 14'b01000000000000,
    ST_EMIT  = 14'b10000000000000
  } state_t;

  // floor(2^32 / i) for the Horner divisors; one below 2^32 when i is one.
  function automatic logic [32:0] horner_recip(input logic [3:0] i);
    logic [32:0] r;
    case (i)
      4'd1:    r = 33'h0_FFFF_FFFF;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = Q_MAX;
    else if (v < -50'sd2147483648) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'(S48_MAX)) r = S48_MAX;
    else if (v < 50'(S48_MIN)) r = S48_MIN;
    else r = v[47:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/linear_err_risk_set_likelihood.sv
// Top level: risk-set likelihood contribution and dose coefficient bound.
`default_nettype none
//  channel | signals                                      | direction
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | in  (ready always high)
//  in      | in_valid, in_ready, covariates, flags        | in
//  out     | out_valid, out_ready, contribution, ...      | out
// A subject runs from idle through the multiplier passes for the sums, range reduction,
// a multiply, divide and correct step for each of the ten Horner terms, scaling, and the
// risk multiply and accumulate; a saturated exponential skips the Horner terms and scaling.
// A set end adds three serial divisions (a zero divisor skips the bit loop) and an emit
// state to present the result. Synchronous reset clears the sums and registers;
// the bound resets to the most negative value. A waiting result stalls only the next set end.
module linear_err_risk_set_likelihood (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  lnerr_pkg::q16_t   lin_x_a,
  input  lnerr_pkg::q16_t   lin_x_b,
  input  lnerr_pkg::q16_t   lin_x_c,
  input  lnerr_pkg::q16_t   log_x_a,
  input  lnerr_pkg::q16_t   log_x_b,
  input  lnerr_pkg::q16_t   log_x_c,
  input  lnerr_pkg::q16_t   log_x_d,
  input  logic              is_case,
  input  logic              set_end,
  output logic              out_valid,
  input  logic              out_ready,
  output lnerr_pkg::q16_t   contribution,
  output lnerr_pkg::q16_t   coef_bound,
  output logic              div_fault
);
  import lnerr_pkg::*;

  state_t state;

  q16_t coef_lin [3];
  q16_t coef_log [4];
  logic [1:0] dose_select;

  q16_t x_lin [3];
  q16_t x_log [4];
  logic case_flag, end_flag;

  logic signed [47:0] risk_sum, case_risk, dose_sum;
  q16_t case_dose;
  logic [15:0] subject_count;
  q16_t bound_reg;

  logic [2:0] cnt;
  logic signed [49:0] acc_lin, acc_log;
  logic [20:0] xp;
  logic [5:0] k;
  logic [29:0] r30;
  logic [31:0] p, t;
  logic [3:0] hi;
  logic [30:0] e;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // Divider state.
  logic [1:0] op;
  logic [63:0] dvd;
  logic [47:0] den, rem;
  logic [5:0] dcnt;
  logic num_neg, num_zero, den_neg, den_zero, fault;
  q16_t contrib;

  q16_t s_lin, s_log;
  logic signed [31:0] s_log_off;
  logic [20:0] xp_c;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  assign s_lin = sat32(acc_lin);
  assign s_log = sat32(acc_log);
  assign s_log_off = s_log + 32'(EXP_OFFS);
  assign xp_c = s_log_off[20:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MAC: begin
        if (cnt < 3'd3) begin
          if (32'(cnt) < N_LIN) begin
            mul_a = 33'(coef_lin[cnt[1:0]]);
            mul_b = 33'(x_lin[cnt[1:0]]);
          end
        end else if (cnt < 3'd7) begin
          if (32'(cnt - 3'd3) < N_LOGLIN) begin
            mul_a = 33'(coef_log[2'(cnt - 3'd3)]);
            mul_b = 33'(x_log[2'(cnt - 3'd3)]);
          end
        end
      end
      ST_EXP0: begin
        mul_a = {12'd0, xp_c};
        mul_b = LN2_RECIP;
      end
      ST_HMUL: begin
        mul_a = {3'd0, r30};
        mul_b = {1'b0, p};
      end
      ST_HDIV: begin
        mul_a = {1'b0, prod[61:30]};
        mul_b = horner_recip(hi);
      end
      ST_RMUL: begin
        mul_a = {2'd0, e};
        mul_b = 33'(s_lin) + 33'sd65536;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Range reduction correction.
  logic [5:0] q0k;
  logic [21:0] remk;
  assign q0k  = prod[37:32];
  assign remk = {1'b0, xp} - 22'(q0k) * 22'(LN2_Q16);

  // Horner quotient correction.
  logic [31:0] q0h, remh, qh;
  logic [35:0] q0h_i;
  assign q0h   = prod[63:32];
  assign q0h_i = q0h * hi;
  assign remh  = t - q0h_i[31:0];
  assign qh    = (remh >= 32'(hi)) ? q0h + 32'd1 : q0h;

  // Scale the series by 2^(k-32) with rounding.
  logic [32:0] ev;
  logic [5:0]  sh;
  logic [32:0] rnd;
  always_comb begin
    sh  = 6'd32 - k;
    rnd = '0;
    ev  = '0;
    if (k > 6'd33) begin
      ev = 33'h0_7FFF_FFFF;
    end else if (k == 6'd33) begin
      ev = {p, 1'b0};
    end else if (k == 6'd32) begin
      ev = {1'b0, p};
    end else begin
      rnd = 33'd1 << (sh - 6'd1);
      ev  = ({1'b0, p} + rnd) >> sh;
    end
  end

  // Risk and sums.
  logic signed [47:0] risk;
  q16_t dose;
  assign risk = sat48(prod[65:16]);
  always_comb begin
    dose = '0;
    if (32'(dose_select) < N_LIN && dose_select != 2'd3) dose = x_lin[dose_select];
  end

  // Division operands for each set-end operation.
  logic [63:0] num_mag_c;
  logic [47:0] den_mag_c;
  logic num_neg_c, num_zero_c, den_neg_c;
  logic signed [63:0] num_c;
  logic signed [47:0] den_c;
  always_comb begin
    case (op)
      OP_CONTRIB: begin
        num_c = {case_risk, 16'd0};
        den_c = risk_sum;
      end
      OP_CASE: begin
        num_c = -64'sd4294967296;
        den_c = 48'(case_dose);
      end
      default: begin
        num_c = -{16'd0, subject_count, 32'd0};
        den_c = dose_sum;
      end
    endcase
    num_neg_c  = num_c[63];
    num_zero_c = (num_c == '0);
    den_neg_c  = den_c[47];
    num_mag_c  = num_neg_c ? 64'(-num_c) : num_c;
    den_mag_c  = den_neg_c ? 48'(-den_c) : den_c;
  end

  logic [48:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem, dvd[63]};
  assign rem_ge = rem_sh >= {1'b0, den};

  q16_t dres;
  always_comb begin
    if (den_zero) begin
      dres = num_neg ? Q_MIN : (num_zero ? '0 : Q_MAX);
    end else if (num_neg != den_neg) begin
      dres = (dvd > 64'h8000_0000) ? Q_MIN : 32'(-dvd);
    end else begin
      dres = (dvd > 64'h7FFF_FFFF) ? Q_MAX : dvd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      coef_lin      <= '{default: '0};
      coef_log      <= '{default: '0};
      dose_select   <= '0;
      risk_sum      <= '0;
      case_risk     <= '0;
      dose_sum      <= '0;
      case_dose     <= '0;
      subject_count <= '0;
      bound_reg     <= Q_MIN;
      out_valid     <= 1'b0;
      cnt           <= '0;
      op            <= OP_CONTRIB;
      fault         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIN_A:    coef_lin[0] <= cfg_data;
          REG_LIN_B:    coef_lin[1] <= cfg_data;
          REG_LIN_C:    coef_lin[2] <= cfg_data;
          REG_LOG_A:    coef_log[0] <= cfg_data;
          REG_LOG_B:    coef_log[1] <= cfg_data;
          REG_LOG_C:    coef_log[2] <= cfg_data;
          REG_LOG_D:    coef_log[3] <= cfg_data;
          REG_DOSE_SEL: dose_select <= cfg_data[1:0];
          default:      ;
        endcase
      end
      // The emit state sets the flag itself when it presents a new result.
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x_lin     <= '{lin_x_a, lin_x_b, lin_x_c};
            x_log     <= '{log_x_a, log_x_b, log_x_c, log_x_d};
            case_flag <= is_case;
            end_flag  <= set_end;
            acc_lin   <= '0;
            acc_log   <= '0;
            cnt       <= '0;
            state     <= ST_MAC;
          end
        end
        ST_MAC: begin
          // The product issued in the previous cycle arrives now.
          if (cnt != 3'd0) begin
            if (cnt <= 3'd3) acc_lin <= acc_lin + prod[65:16];
            else acc_log <= acc_log + prod[65:16];
          end
          if (cnt == 3'd7) state <= ST_EXP0;
          else cnt <= cnt + 3'd1;
        end
        ST_EXP0: begin
          xp <= xp_c;
          if (s_log >= EXP_HI) begin
            e     <= 31'h7FFF_FFFF;
            state <= ST_RMUL;
          end else if (s_log < EXP_LO) begin
            e     <= '0;
            state <= ST_RMUL;
          end else begin
            state <= ST_EXP1;
          end
        end
        ST_EXP1: begin
          if (remk >= 22'(LN2_Q16)) begin
            k   <= q0k + 6'd1;
            r30 <= {16'(remk - 22'(LN2_Q16)), 14'd0};
          end else begin
            k   <= q0k;
            r30 <= {remk[15:0], 14'd0};
          end
          p     <= ONE_Q30;
          hi    <= HORNER_TERMS;
          state <= ST_HMUL;
        end
        ST_HMUL: state <= ST_HDIV;
        ST_HDIV: begin
          t     <= prod[61:30];
          state <= ST_HCOR;
        end
        ST_HCOR: begin
          p <= ONE_Q30 + qh;
          if (hi == 4'd1) state <= ST_EXPF;
          else begin
            hi    <= hi - 4'd1;
            state <= ST_HMUL;
          end
        end
        ST_EXPF: begin
          e     <= (ev > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : ev[30:0];
          state <= ST_RMUL;
        end
        ST_RMUL: state <= ST_RACC;
        ST_RACC: begin
          risk_sum <= sat48(50'(risk_sum) + 50'(risk));
          dose_sum <= sat48(50'(dose_sum) + 50'(dose));
          if (32'(subject_count) < SET_MAX) subject_count <= subject_count + 16'd1;
          if (case_flag) begin
            case_risk <= risk;
            case_dose <= dose;
          end
          if (end_flag) begin
            op    <= OP_CONTRIB;
            fault <= 1'b0;
            state <= ST_DLOAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DLOAD: begin
          dvd      <= num_mag_c;
          den      <= den_mag_c;
          rem      <= '0;
          dcnt     <= 6'd63;
          num_neg  <= num_neg_c;
          num_zero <= num_zero_c;
          den_neg  <= den_neg_c;
          den_zero <= (den_mag_c == '0);
          state    <= (den_mag_c == '0) ? ST_DFIN : ST_DITER;
        end
        ST_DITER: begin
          // One quotient bit per cycle; quotient bits shift in behind the dividend.
          rem <= rem_ge ? 48'(rem_sh - {1'b0, den}) : rem_sh[47:0];
          dvd <= {dvd[62:0], rem_ge};
          if (dcnt == 6'd0) state <= ST_DFIN;
          else dcnt <= dcnt - 6'd1;
        end
        ST_DFIN: begin
          if (den_zero) fault <= 1'b1;
          if (op == OP_CONTRIB) contrib <= dres;
          else if (bound_reg <= dres) bound_reg <= dres;
          if (op == OP_COUNT) state <= ST_EMIT;
          else begin
            op    <= op + 2'd1;
            state <= ST_DLOAD;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            contribution  <= contrib;
            coef_bound    <= bound_reg;
            div_fault     <= fault;
            out_valid     <= 1'b1;
            risk_sum      <= '0;
            case_risk     <= '0;
            dose_sum      <= '0;
            case_dose     <= '0;
            subject_count <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MAC))
    else $error("request accepted but sequencer did not start");

  a_set_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DLOAD) |-> (subject_count != 16'd0))
    else $error("set end reached with an empty subject count");

  a_horner_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HMUL || state == ST_HDIV || state == ST_HCOR) |->
    (hi != 4'd0 && hi <= HORNER_TERMS))
    else $error("Horner term index out of range");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
    else $error("result not presented after set end");
`endif

endmodule
`default_nettype wire

>>> test/lnerr_checker.sv
// Checker: predicts each risk-set result from the accepted requests and compares it.
module lnerr_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [3:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  input  logic            in_ready,
  input  lnerr_pkg::q16_t lin_x_a,
  input  lnerr_pkg::q16_t lin_x_b,
  input  lnerr_pkg::q16_t lin_x_c,
  input  lnerr_pkg::q16_t log_x_a,
  input  lnerr_pkg::q16_t log_x_b,
  input  lnerr_pkg::q16_t log_x_c,
  input  lnerr_pkg::q16_t log_x_d,
  input  logic            is_case,
  input  logic            set_end,
  input  logic            out_valid,
  input  logic            out_ready,
  input  lnerr_pkg::q16_t contribution,
  input  lnerr_pkg::q16_t coef_bound,
  input  logic            div_fault,
  output int              pending,
  output int              fail_count
);
  import lnerr_pkg::*;

  typedef struct packed {
    logic signed [31:0] contrib;
    logic signed [31:0] bound;
    logic               fault;
  } set_result_t;

  localparam longint L32_MAX = 64'sd2147483647;
  localparam longint L32_MIN = -64'sd2147483648;
  localparam longint L48_MAX = 64'sd140737488355327;
  localparam longint L48_MIN = -64'sd140737488355328;

  set_result_t        result_q[$];
  logic signed [31:0] lin_coef[3];
  logic signed [31:0] log_coef[4];
  logic [1:0]         dose_sel;
  longint             risk_acc, case_risk_v, dose_acc, case_dose_v, bound_v;
  int unsigned        count_v;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint exp_fix(longint x);
    longint unsigned xp, k, r, r30, p, v, iu;
    int unsigned s;
    if (x >= longint'(EXP_HI)) return L32_MAX;
    if (x < longint'(EXP_LO)) return 0;
    xp = x + longint'(EXP_OFFS);
    k = xp / LN2_Q16;
    r = xp - k * LN2_Q16;
    r30 = r << 14;
    p = 64'd1 << 30;
    for (iu = 10; iu >= 1; iu--)
      p = (64'd1 << 30) + ((r30 * p) >> 30) / iu;
    if (k > 33) return L32_MAX;
    if (k == 33) v = p << 1;
    else if (k == 32) v = p;
    else begin
      s = 32 - int'(k);
      v = (p + (64'd1 << (s - 1))) >> s;
    end
    return v > 64'd2147483647 ? L32_MAX : longint'(v);
  endfunction

  function automatic longint quot_sat(longint num, longint den, inout bit fault);
    longint unsigned un, ud, q;
    if (den == 0) begin
      fault = 1'b1;
      return num < 0 ? L32_MIN : (num > 0 ? L32_MAX : 0);
    end
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = un / ud;
    if ((num < 0) != (den < 0)) return q > 64'd2147483648 ? L32_MIN : -longint'(q);
    return q > 64'd2147483647 ? L32_MAX : longint'(q);
  endfunction

  task automatic take_subject();
    longint xl[3], xg[4], acc, s_lin, s_log, e, risk, dose, b;
    bit fault;
    set_result_t res;
    xl[0] = lin_x_a; xl[1] = lin_x_b; xl[2] = lin_x_c;
    xg[0] = log_x_a; xg[1] = log_x_b; xg[2] = log_x_c; xg[3] = log_x_d;
    fault = 1'b0;
    acc = 0;
    for (int j = 0; j < N_LIN; j++) acc += (longint'(lin_coef[j]) * xl[j]) >>> 16;
    s_lin = clamp(acc, L32_MIN, L32_MAX);
    acc = 0;
    for (int j = 0; j < N_LOGLIN; j++) acc += (longint'(log_coef[j]) * xg[j]) >>> 16;
    s_log = clamp(acc, L32_MIN, L32_MAX);
    e = exp_fix(s_log);
    risk = clamp((e * (65536 + s_lin)) >>> 16, L48_MIN, L48_MAX);
    dose = dose_sel < N_LIN ? xl[dose_sel] : 0;
    risk_acc = clamp(risk_acc + risk, L48_MIN, L48_MAX);
    dose_acc = clamp(dose_acc + dose, L48_MIN, L48_MAX);
    if (count_v < SET_MAX) count_v++;
    if (is_case) begin
      case_risk_v = risk;
      case_dose_v = dose;
    end
    if (set_end) begin
      res.contrib = quot_sat(case_risk_v * 65536, risk_acc, fault);
      b = quot_sat(-64'sd4294967296, case_dose_v, fault);
      if (bound_v <= b) bound_v = b;
      b = quot_sat(-(longint'(count_v) * 64'sd4294967296), dose_acc, fault);
      if (bound_v <= b) bound_v = b;
      res.bound = bound_v;
      res.fault = fault;
      result_q.push_back(res);
      risk_acc = 0; case_risk_v = 0; dose_acc = 0; case_dose_v = 0; count_v = 0;
    end
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      foreach (lin_coef[j]) lin_coef[j] = '0;
      foreach (log_coef[j]) log_coef[j] = '0;
      dose_sel = '0;
      risk_acc = 0; case_risk_v = 0; dose_acc = 0; case_dose_v = 0; count_v = 0;
      bound_v = L32_MIN;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIN_A:    lin_coef[0] = cfg_data;
          REG_LIN_B:    lin_coef[1] = cfg_data;
          REG_LIN_C:    lin_coef[2] = cfg_data;
          REG_LOG_A:    log_coef[0] = cfg_data;
          REG_LOG_B:    log_coef[1] = cfg_data;
          REG_LOG_C:    log_coef[2] = cfg_data;
          REG_LOG_D:    log_coef[3] = cfg_data;
          REG_DOSE_SEL: dose_sel = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_subject();
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with no request waiting: %h %h %b", $time,
                   contribution, coef_bound, div_fault);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (contribution !== want.contrib) begin
            $display("%0t: contribution expected %h actual %h", $time, want.contrib,
                     contribution);
            fail_count++;
          end
          if (coef_bound !== want.bound) begin
            $display("%0t: coef_bound expected %h actual %h", $time, want.bound, coef_bound);
            fail_count++;
          end
          if (div_fault !== want.fault) begin
            $display("%0t: div_fault expected %b actual %b", $time, want.fault, div_fault);
            fail_count++;
          end
        end
      end
    end
    pending = result_q.size();
  end
endmodule

>>> test/tb_linear_err_risk_set_likelihood.sv
// Testbench top: drives subjects and register writes and reports the verdict.
module tb_linear_err_risk_set_likelihood;
  import lnerr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  q16_t lin_x_a = '0, lin_x_b = '0, lin_x_c = '0;
  q16_t log_x_a = '0, log_x_b = '0, log_x_c = '0, log_x_d = '0;
  logic is_case = 1'b0, set_end = 1'b0;
  logic out_valid, out_ready = 1'b0;
  q16_t contribution, coef_bound;
  logic div_fault;
  int pending, fail_count;
  int tx_idle = 0, rx_idle = 0;

  always #2 clk = ~clk;

  linear_err_risk_set_likelihood dut (.*);
  lnerr_checker chk (.*);

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  function automatic logic [31:0] rand_cov();
    logic [31:0] pick[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return pick[$urandom_range(4)];
      default: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return '0;
      default: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
    endcase
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic [31:0] la, lb, lc, ga, gb, gc, gd, logic [1:0] dsel);
    write_reg(REG_LIN_A, la);
    write_reg(REG_LIN_B, lb);
    write_reg(REG_LIN_C, lc);
    write_reg(REG_LOG_A, ga);
    write_reg(REG_LOG_B, gb);
    write_reg(REG_LOG_C, gc);
    write_reg(REG_LOG_D, gd);
    write_reg(REG_DOSE_SEL, {30'd0, dsel});
  endtask

  task automatic send_subject(logic [31:0] la, lb, lc, ga, gb, gc, gd, logic c, e);
    if ($urandom_range(99) < tx_idle) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    lin_x_a = la; lin_x_b = lb; lin_x_c = lc;
    log_x_a = ga; log_x_b = gb; log_x_c = gc; log_x_d = gd;
    is_case = c; set_end = e;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  // Waits for every outstanding result and then lets the block settle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic random_sets(int n_items);
    int sent, size, case_at;
    sent = 0;
    while (sent < n_items) begin
      size = ($urandom_range(19) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
      case_at = $urandom_range(0, size - 1);
      // Now and then a set with no case or with a second case.
      if ($urandom_range(9) == 0) case_at = -1;
      for (int j = 0; j < size; j++)
        send_subject(rand_cov(), rand_cov(), rand_cov(), rand_cov(), rand_cov(), rand_cov(),
                     rand_cov(), (j == case_at) || ($urandom_range(11) == 0),
                     (j == size - 1) || ($urandom_range(49) == 0));
      sent += size;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    // Reset settings: unit risk, zero dose, so the bound divisions fault.
    send_subject(0, 0, 0, 0, 0, 0, 0, 1, 1);
    send_subject(0, 0, 0, 0, 0, 0, 0, 0, 1);
    drain();
    write_all(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000,
              32'h0000_4000, 32'h0, 2'd0);
    send_subject(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 0, 0, 0, 1, 1);
    send_subject(32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    send_subject(32'h0003_0000, 0, 0, 0, 0, 0, 0, 0, 1);
    send_subject(32'h0001_0000, 0, 0, 0, 0, 0, 0, 1, 0);
    send_subject(32'hFFFE_0000, 0, 0, 32'h0002_0000, 0, 0, 0, 1, 1);
    send_subject(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1);
    send_subject(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 1, 1);
    send_subject(32'hFFFF_FFFF, 0, 32'h0000_0001, 32'h0010_0000, 32'h0, 0, 0, 1, 1);
    drain();
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'd2);
    send_subject(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0100, 0, 0, 0, 1, 1);
    send_subject(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'hFFF0_0000, 0, 0, 0, 1, 1);
    drain();
    write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 2'd3);
    send_subject(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0100, 0, 0, 0, 1, 1);
    send_subject(32'hFFFF_0000, 0, 0, 32'hFFFF_FF00, 0, 0, 0, 0, 1);
    drain();

    for (int m = 0; m < 3; m++) begin
      tx_idle = (m == 0) ? 11 : (m == 1) ? 87 : 0;
      rx_idle = (m == 0) ? 87 : (m == 1) ? 11 : 0;
      for (int ph = 0; ph < 4; ph++) begin
        write_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  rand_coef(), rand_coef(), 2'($urandom_range(0, ph == 3 ? 3 : 2)));
        random_sets(125);
        drain();
      end
    end

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end
endmodule
